// ===== src/gzhp_pkg.sv =====
// Shared types, constants and helpers for the gzip member header parser.
package gzhp_pkg;

  localparam int LENGTH_BITS  = 24;  // width of the internal byte counter
  localparam int HDR_LEN_W    = 24;  // width of the reported header length
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [7:0]  MAGIC1_BYTE  = 8'h1F;
  localparam logic [7:0]  MAGIC2_BYTE  = 8'h8B;
  localparam logic [7:0]  METHOD_DEFL  = 8'h08;
  localparam logic [7:0]  FL_HCRC      = 8'h02;
  localparam logic [7:0]  FL_EXTRA     = 8'h04;
  localparam logic [7:0]  FL_NAME      = 8'h08;
  localparam logic [7:0]  FL_COMMENT   = 8'h10;
  localparam logic [7:0]  FL_RESERVED  = 8'hE0;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
  localparam logic [23:0] FIXED_END    = 24'd10;  // MTIME/XFL/OS end at byte 10

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN_LO = 4'd5,
    PH_XLEN_HI = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC_LO = 4'd10,
    PH_HCRC_HI = 4'd11,
    PH_DONE    = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_METH  = 3'd3,
    ST_RSVD_FLAG = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_HCRC_BAD  = 3'd6
  } status_t;

  // First enabled optional section at or after the given phase.
  function automatic phase_t next_section(phase_t from, logic [7:0] flags);
    phase_t res;
    res = PH_DONE;
    if (from <= PH_HCRC_LO && (flags & FL_HCRC) != 8'h00) res = PH_HCRC_LO;
    if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'h00) res = PH_COMMENT;
    if (from <= PH_NAME && (flags & FL_NAME) != 8'h00) res = PH_NAME;
    if (from <= PH_XLEN_LO && (flags & FL_EXTRA) != 8'h00) res = PH_XLEN_LO;
    return res;
  endfunction

endpackage

// ===== src/gzhp_crc_byte.sv =====
// Bytewise reflected CRC-32 update (poly 0xEDB88320), one byte per cycle.
module gzhp_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'h000000, data_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ gzhp_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// ===== src/gzip_member_header_parser_unit.sv =====
// Top level: gzip member header parser, one header byte per transfer.
//
//  channel | dir | tdata (low bit up)                    | tlast
//  --------+-----+---------------------------------------+-------------
//  in_     | in  | [7:0] data_byte                       | end_of_data
//  out_    | out | [2:0] status, [26:3] header_length,   | -
//          |     | [31:27] zero                          |
//
// Cycles: one byte accepted per clock while in_tready is high; its result
//   appears in the output register the next cycle. Phase step and bytewise
//   CRC-32 update are combinational, feeding state and output registers.
// Reset: rst_n synchronous, active low; parser waits for the first magic byte.
// Stalls: in_tready is high while the output register is empty or being
//   drained, so a held result costs no bubble once it is taken.
// After a done or error result, all parse state returns to its reset values.
module gzip_member_header_parser_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gzhp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // end_of_data
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gzhp_pkg::OUT_TDATA_W-1:0]   out_tdata   // [2:0] status, [26:3] length
);

  // parse state
  gzhp_pkg::phase_t                  phase_r,  phase_nxt;
  logic [gzhp_pkg::LENGTH_BITS-1:0]  offset_r, offset_nxt;
  logic [7:0]                        flags_r,  flags_nxt;
  logic [15:0]                       extra_r,  extra_nxt;
  logic [31:0]                       crc_r,    crc_nxt;
  logic [7:0]                        crc_lo_r, crc_lo_nxt;

  // output register
  logic                              out_valid_r;
  logic [gzhp_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic                              in_xfer;
  logic [7:0]                        b;
  logic [31:0]                       crc_upd;
  gzhp_pkg::status_t                 status;
  gzhp_pkg::phase_t                  cur_phase;
  logic [15:0]                       extra_hi;
  logic [15:0]                       extra_dec;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign b          = in_tdata[7:0];

  gzhp_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (b),
    .crc_out (crc_upd)
  );

  assign extra_hi  = {b, extra_r[7:0]};
  assign extra_dec = extra_r - 16'd1;

  always_comb begin
    // saturating byte count, this byte included
    offset_nxt = (offset_r == {gzhp_pkg::LENGTH_BITS{1'b1}}) ? offset_r
                                                              : offset_r + 1'b1;
    // codes past the CRC bytes restart at the first magic byte
    cur_phase  = (phase_r > gzhp_pkg::PH_HCRC_HI) ? gzhp_pkg::PH_MAGIC1 : phase_r;
    phase_nxt  = cur_phase;
    flags_nxt  = flags_r;
    extra_nxt  = extra_r;
    crc_lo_nxt = crc_lo_r;
    crc_nxt    = (cur_phase < gzhp_pkg::PH_HCRC_LO) ? crc_upd : crc_r;
    status     = gzhp_pkg::ST_BUSY;

    unique case (cur_phase)
      gzhp_pkg::PH_MAGIC1: begin
        if (b != gzhp_pkg::MAGIC1_BYTE) status = gzhp_pkg::ST_BAD_MAGIC;
        else phase_nxt = gzhp_pkg::PH_MAGIC2;
      end
      gzhp_pkg::PH_MAGIC2: begin
        if (b != gzhp_pkg::MAGIC2_BYTE) status = gzhp_pkg::ST_BAD_MAGIC;
        else phase_nxt = gzhp_pkg::PH_METHOD;
      end
      gzhp_pkg::PH_METHOD: begin
        if (b != gzhp_pkg::METHOD_DEFL) status = gzhp_pkg::ST_BAD_METH;
        else phase_nxt = gzhp_pkg::PH_FLAGS;
      end
      gzhp_pkg::PH_FLAGS: begin
        if ((b & gzhp_pkg::FL_RESERVED) != 8'h00) begin
          status = gzhp_pkg::ST_RSVD_FLAG;
        end else begin
          flags_nxt = b;
          phase_nxt = gzhp_pkg::PH_FIXED;
        end
      end
      gzhp_pkg::PH_FIXED: begin
        if (offset_nxt >= gzhp_pkg::LENGTH_BITS'(gzhp_pkg::FIXED_END))
          phase_nxt = gzhp_pkg::next_section(gzhp_pkg::PH_XLEN_LO, flags_r);
      end
      gzhp_pkg::PH_XLEN_LO: begin
        extra_nxt = {8'h00, b};
        phase_nxt = gzhp_pkg::PH_XLEN_HI;
      end
      gzhp_pkg::PH_XLEN_HI: begin
        extra_nxt = extra_hi;
        phase_nxt = (extra_hi == 16'd0)
                  ? gzhp_pkg::next_section(gzhp_pkg::PH_NAME, flags_r)
                  : gzhp_pkg::PH_EXTRA;
      end
      gzhp_pkg::PH_EXTRA: begin
        extra_nxt = extra_dec;
        if (extra_dec == 16'd0)
          phase_nxt = gzhp_pkg::next_section(gzhp_pkg::PH_NAME, flags_r);
      end
      gzhp_pkg::PH_NAME: begin
        if (b == 8'h00) phase_nxt = gzhp_pkg::next_section(gzhp_pkg::PH_COMMENT, flags_r);
      end
      gzhp_pkg::PH_COMMENT: begin
        if (b == 8'h00) phase_nxt = gzhp_pkg::next_section(gzhp_pkg::PH_HCRC_LO, flags_r);
      end
      gzhp_pkg::PH_HCRC_LO: begin
        crc_lo_nxt = b;
        phase_nxt  = gzhp_pkg::PH_HCRC_HI;
      end
      default: begin
        // second stored CRC byte: compare against low half of final CRC
        if ({b, crc_lo_r} != ~crc_r[15:0]) status = gzhp_pkg::ST_HCRC_BAD;
        else phase_nxt = gzhp_pkg::PH_DONE;
      end
    endcase

    if (status == gzhp_pkg::ST_BUSY && phase_nxt == gzhp_pkg::PH_DONE)
      status = gzhp_pkg::ST_DONE;
    if (status == gzhp_pkg::ST_BUSY && in_tlast)
      status = gzhp_pkg::ST_TRUNC;

    out_data_nxt = {5'b00000, gzhp_pkg::HDR_LEN_W'(offset_nxt), status};

    // any final result starts a fresh header
    if (status != gzhp_pkg::ST_BUSY) begin
      phase_nxt  = gzhp_pkg::PH_MAGIC1;
      offset_nxt = '0;
      flags_nxt  = 8'h00;
      extra_nxt  = 16'd0;
      crc_nxt    = gzhp_pkg::CRC_INIT;
      crc_lo_nxt = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= gzhp_pkg::PH_MAGIC1;
      offset_r <= '0;
      flags_r  <= 8'h00;
      extra_r  <= 16'd0;
      crc_r    <= gzhp_pkg::CRC_INIT;
      crc_lo_r <= 8'h00;
    end else if (in_xfer) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      flags_r  <= flags_nxt;
      extra_r  <= extra_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) out_data_r <= out_data_nxt;
  end

  // a final status restarts the parser at the first magic byte
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && out_data_nxt[2:0] != gzhp_pkg::ST_BUSY
      |=> phase_r == gzhp_pkg::PH_MAGIC1 && offset_r == '0)
    else $error("parser did not restart after final status");

  // byte count is zero exactly when waiting for the first magic byte
  a_offset_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r == '0) == (phase_r == gzhp_pkg::PH_MAGIC1))
    else $error("byte count out of step with phase");

  // CRC is at its initial value at the start of a header
  a_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gzhp_pkg::PH_MAGIC1 |-> crc_r == gzhp_pkg::CRC_INIT)
    else $error("CRC not initialized at header start");

  // the extra field count never sits at zero while skipping extra bytes
  a_extra_nz: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gzhp_pkg::PH_EXTRA |-> extra_r != 16'd0)
    else $error("extra byte count zero in extra phase");

endmodule
